FILE: rtl/vdp_pkg.sv
// ----------------------------------------------------------------------------
// vdp_pkg
// Shared constants and types for the varint delta position decoder.
// ----------------------------------------------------------------------------
package vdp_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int OUT_VALUE_BITS = 32;
  localparam int BYTE_BITS      = 8;
  localparam int PAYLOAD_BITS   = 7;
  localparam int MORE_BIT       = 7;

  localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MASK = 7'h7F;

  localparam logic KIND_COUNT    = 1'b0;
  localparam logic KIND_POSITION = 1'b1;

  typedef struct packed {
    logic done;
    logic overlong;
  } varint_flags_t;

  typedef struct packed {
    logic kind;
    logic list_end;
    logic overlong;
  } result_flags_t;

endpackage

FILE: rtl/vdp_varint_acc.sv
// ----------------------------------------------------------------------------
// vdp_varint_acc
// Gathers base-128 varint bytes into a value and tracks overlong varints.
// ----------------------------------------------------------------------------
module vdp_varint_acc import vdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,
  input  logic [BYTE_BITS-1:0]  data_byte,
  output logic [VALUE_BITS-1:0] acc_value,
  output varint_flags_t         acc_flags
);

  localparam int MaxBytes = (VALUE_BITS + PAYLOAD_BITS - 1) / PAYLOAD_BITS;
  localparam int IdxW     = $clog2(MaxBytes + 1);
  localparam int WideW    = VALUE_BITS + PAYLOAD_BITS;
  localparam int ShiftW   = $clog2(WideW);

  logic [VALUE_BITS-1:0] partial_r, partial_nxt;
  logic [IdxW-1:0]       idx_r, idx_nxt;
  logic                  ovf_r, ovf_nxt;

  logic                  sat;
  logic [ShiftW-1:0]     shift;
  logic [WideW-1:0]      pay_ext;
  logic [WideW-1:0]      shifted;
  logic [VALUE_BITS-1:0] gathered;
  logic                  ovl;
  logic                  last;

  always_comb begin
    sat      = (idx_r >= IdxW'(MaxBytes));
    shift    = ShiftW'(idx_r) * ShiftW'(PAYLOAD_BITS);
    pay_ext  = WideW'(data_byte[PAYLOAD_BITS-1:0] & PAYLOAD_MASK);
    shifted  = pay_ext << shift;
    last     = !data_byte[MORE_BIT];
    if (sat) begin
      gathered = partial_r;
      ovl      = 1'b1;
    end else begin
      gathered = partial_r | shifted[VALUE_BITS-1:0];
      ovl      = ovf_r | (shifted[WideW-1:VALUE_BITS] != '0);
    end
    acc_value          = gathered;
    acc_flags.done     = last;
    acc_flags.overlong = ovl;
    if (last) begin
      partial_nxt = '0;
      idx_nxt     = '0;
      ovf_nxt     = 1'b0;
    end else begin
      partial_nxt = gathered;
      idx_nxt     = sat ? idx_r : idx_r + 1'b1;
      ovf_nxt     = ovl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      idx_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (byte_en) begin
      partial_r <= partial_nxt;
      idx_r     <= idx_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

FILE: rtl/vdp_list_ctrl.sv
// ----------------------------------------------------------------------------
// vdp_list_ctrl
// Tracks list phase, remaining deltas and previous position; forms results.
// ----------------------------------------------------------------------------
module vdp_list_ctrl import vdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  value_en,
  input  logic [VALUE_BITS-1:0] acc_value,
  input  varint_flags_t         acc_flags,
  output logic [VALUE_BITS-1:0] res_value,
  output result_flags_t         res_flags
);

  logic                  in_deltas_r, in_deltas_nxt;
  logic [VALUE_BITS-1:0] remaining_r, remaining_nxt;
  logic [VALUE_BITS-1:0] prev_r, prev_nxt;
  logic [VALUE_BITS-1:0] position;

  always_comb begin
    position      = prev_r + acc_value;
    remaining_nxt = remaining_r;
    in_deltas_nxt = in_deltas_r;
    res_flags.overlong = acc_flags.overlong;
    if (!in_deltas_r) begin
      res_flags.kind     = KIND_COUNT;
      res_value          = acc_value;
      res_flags.list_end = (acc_value == '0);
      prev_nxt           = '0;
      if (acc_value != '0) begin
        in_deltas_nxt = 1'b1;
        remaining_nxt = acc_value;
      end
    end else begin
      res_flags.kind     = KIND_POSITION;
      res_value          = position;
      prev_nxt           = position;
      remaining_nxt      = remaining_r - 1'b1;
      res_flags.list_end = (remaining_nxt == '0);
      if (remaining_nxt == '0) begin
        in_deltas_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_deltas_r <= 1'b0;
      remaining_r <= '0;
      prev_r      <= '0;
    end else if (value_en && acc_flags.done) begin
      in_deltas_r <= in_deltas_nxt;
      remaining_r <= remaining_nxt;
      prev_r      <= prev_nxt;
    end
  end

endmodule

FILE: rtl/varint_delta_position_decoder_unit.sv
// ----------------------------------------------------------------------------
// varint_delta_position_decoder_unit
// Decodes varint-coded position lists from a byte stream into counts and
// absolute positions.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock with no bubbles, unless a final
// byte is held off by a waiting result. A byte is held in an input register,
// decoded by the varint accumulator and list tracker, and a completed varint
// lands in the result register. Continuation bytes give no result. The rate of
// one byte per cycle is set by the update of the varint and list state, which
// takes each byte as it leaves the input register. While a result waits under
// out_stall the input register still drains continuation bytes; a final byte
// waits in it and holds off the input until the waiting result is taken.
module varint_delta_position_decoder_unit import vdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [BYTE_BITS-1:0]      in_data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_value_kind,
  output logic [OUT_VALUE_BITS-1:0] out_value,
  output logic                      out_list_end,
  output logic                      out_overlong
);

  logic                 s1_valid_r;
  logic [BYTE_BITS-1:0] s1_byte_r;
  logic                 out_valid_r;
  logic                 out_adv;
  logic                 s1_last;
  logic                 s1_take;
  logic                 in_take;

  logic [VALUE_BITS-1:0]                acc_value;
  varint_flags_t                        acc_flags;
  logic [VALUE_BITS-1:0]                res_value;
  result_flags_t                        res_flags;
  logic [VALUE_BITS+OUT_VALUE_BITS-1:0] res_ext;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_last  = !s1_byte_r[MORE_BIT];
  assign s1_take  = s1_valid_r && (!s1_last || out_adv);
  assign in_stall = s1_valid_r && !s1_take;
  assign in_take  = in_valid && !in_stall;
  assign res_ext  = {{OUT_VALUE_BITS{1'b0}}, res_value};

  vdp_varint_acc #(.VALUE_BITS(VALUE_BITS)) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (s1_take),
    .data_byte (s1_byte_r),
    .acc_value (acc_value),
    .acc_flags (acc_flags)
  );

  vdp_list_ctrl #(.VALUE_BITS(VALUE_BITS)) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .value_en  (s1_take),
    .acc_value (acc_value),
    .acc_flags (acc_flags),
    .res_value (res_value),
    .res_flags (res_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last) begin
      out_value_kind <= res_flags.kind;
      out_value      <= res_ext[OUT_VALUE_BITS-1:0];
      out_list_end   <= res_flags.list_end;
      out_overlong   <= res_flags.overlong;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/vdp_checker.sv
// ----------------------------------------------------------------------------
// vdp_checker
// Port-level checks for the varint delta position decoder, bound to the top.
// ----------------------------------------------------------------------------
module vdp_checker import vdp_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_value_kind,
  input logic [OUT_VALUE_BITS-1:0] out_value,
  input logic                      out_list_end,
  input logic                      out_overlong
);

  // stalled request stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped under stall");

  // stalled request keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_value_kind)
      && $stable(out_list_end) && $stable(out_overlong))
    else $error("out payload changed under stall");

  // nothing offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a nonzero count opens a list
  a_count_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_kind == KIND_COUNT && out_value != '0 |-> !out_list_end)
    else $error("nonzero count closed the list");

  // a zero count is an empty list
  a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (VALUE_BITS <= OUT_VALUE_BITS) && out_valid && out_value_kind == KIND_COUNT
      && out_value == '0 |-> out_list_end)
    else $error("zero count did not close the list");

endmodule

bind varint_delta_position_decoder_unit vdp_checker #(.VALUE_BITS(VALUE_BITS)) u_vdp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value_kind (out_value_kind),
  .out_value      (out_value),
  .out_list_end   (out_list_end),
  .out_overlong   (out_overlong)
);

FILE: sim/vdp_position_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vdp_position_checker
// Watches both channels of the varint delta position decoder. It rebuilds the
// counts and absolute positions from every accepted byte, and compares each
// accepted result field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module vdp_position_checker import vdp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [BYTE_BITS-1:0]      in_data_byte,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_value_kind,
  input  logic [OUT_VALUE_BITS-1:0] out_value,
  input  logic                      out_list_end,
  input  logic                      out_overlong,
  output int                        mismatches,
  output int                        outstanding,
  output int                        checked,
  output int                        overlong_hits
);

  localparam int MAX_BYTES = (VALUE_BITS_DEF + 6) / PAYLOAD_BITS;

  typedef struct packed {
    logic                      kind;
    logic [OUT_VALUE_BITS-1:0] value;
    logic                      list_end;
    logic                      overlong;
  } decoded_t;

  logic [VALUE_BITS_DEF-1:0] acc;
  int                        nbytes;
  logic                      spill;
  logic                      in_list;
  logic [VALUE_BITS_DEF-1:0] left;
  logic [VALUE_BITS_DEF-1:0] last_pos;
  decoded_t                  due_results[$];

  task automatic report(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic decode_byte(input logic [BYTE_BITS-1:0] b);
    logic [PAYLOAD_BITS-1:0] pay;
    int                      shift;
    decoded_t                r;
    pay = b[PAYLOAD_BITS-1:0];
    if (nbytes >= MAX_BYTES) begin
      spill = 1'b1;
    end else begin
      shift = nbytes * PAYLOAD_BITS;
      if (VALUE_BITS_DEF - shift < PAYLOAD_BITS && (pay >> (VALUE_BITS_DEF - shift)) != 0)
        spill = 1'b1;
      acc = acc | VALUE_BITS_DEF'(64'(pay) << shift);
      nbytes++;
    end
    if (b[MORE_BIT])
      return;
    r.overlong = spill;
    r.value = acc;
    acc = '0;
    nbytes = 0;
    spill = 1'b0;
    if (!in_list) begin
      r.kind = KIND_COUNT;
      r.list_end = (r.value == 0);
      if (r.value != 0) begin
        in_list = 1'b1;
        left = r.value;
      end
      last_pos = '0;
    end else begin
      r.kind = KIND_POSITION;
      r.value = last_pos + r.value;
      last_pos = r.value;
      left = left - 1'b1;
      r.list_end = (left == 0);
      if (left == 0)
        in_list = 1'b0;
    end
    due_results.push_back(r);
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst_n) begin
      acc = '0;
      nbytes = 0;
      spill = 1'b0;
      in_list = 1'b0;
      left = '0;
      last_pos = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report($sformatf("unexpected request kind %0d value %h", out_value_kind, out_value));
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.overlong)
            overlong_hits++;
          if (out_value_kind !== want.kind)
            report($sformatf("value_kind got %0d want %0d", out_value_kind, want.kind));
          if (out_value !== want.value)
            report($sformatf("value got %h want %h", out_value, want.value));
          if (out_list_end !== want.list_end)
            report($sformatf("list_end got %0d want %0d", out_list_end, want.list_end));
          if (out_overlong !== want.overlong)
            report($sformatf("overlong got %0d want %0d", out_overlong, want.overlong));
        end
      end
      if (in_valid && !in_stall)
        decode_byte(in_data_byte);
    end
    outstanding <= due_results.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte stream stimulus for the varint delta position decoder. A short run of
// hand-made lists covers empty lists, wrap, the largest delta and overlong
// varints; random lists with minimal, padded, overlong and spilling varints
// follow, mixed with cut-short lists and stray bytes, under random bursts and
// output stalls. Results are checked by vdp_position_checker.
// ----------------------------------------------------------------------------
module tb;
  import vdp_pkg::*;

  localparam int MAX_LEN   = (VALUE_BITS_DEF + 6) / PAYLOAD_BITS;
  localparam int RAND_REQS = 1150;

  typedef enum int {
    FORM_MIN,
    FORM_PAD,
    FORM_LONG,
    FORM_SPILL
  } varint_form_e;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [BYTE_BITS-1:0]      in_data_byte;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_value_kind;
  logic [OUT_VALUE_BITS-1:0] out_value;
  logic                      out_list_end;
  logic                      out_overlong;

  int mismatches;
  int outstanding;
  int checked;
  int overlong_hits;
  int sent;
  int lists_sent;
  int burst_left;
  int holds;

  varint_delta_position_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_kind (out_value_kind),
    .out_value      (out_value),
    .out_list_end   (out_list_end),
    .out_overlong   (out_overlong)
  );

  vdp_position_checker position_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_kind (out_value_kind),
    .out_value      (out_value),
    .out_list_end   (out_list_end),
    .out_overlong   (out_overlong),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .checked        (checked),
    .overlong_hits  (overlong_hits)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic put_byte(input logic [BYTE_BITS-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic put_varint(input logic [31:0] v, input varint_form_e form);
    logic [31:0]             rest;
    logic [PAYLOAD_BITS-1:0] pay;
    logic                    more;
    int                      len;
    int                      n;
    int                      extra;
    len = 1;
    rest = v >> PAYLOAD_BITS;
    while (rest != 0) begin
      len++;
      rest = rest >> PAYLOAD_BITS;
    end
    case (form)
      FORM_MIN: n = len;
      FORM_PAD: n = $urandom_range(len, MAX_LEN);
      default:  n = MAX_LEN;
    endcase
    for (int i = 0; i < n; i++) begin
      pay = PAYLOAD_BITS'(v >> (PAYLOAD_BITS * i));
      if (form == FORM_SPILL && i == MAX_LEN - 1)
        pay[6:4] = 3'($urandom_range(1, 7));
      more = (i < n - 1) || (form == FORM_LONG);
      put_byte({more, pay});
    end
    if (form == FORM_LONG) begin
      extra = $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) begin
        more = (i < extra - 1);
        put_byte({more, PAYLOAD_BITS'($urandom)});
      end
    end
  endtask

  function automatic varint_form_e pick_form();
    int r;
    r = $urandom_range(99);
    if (r < 76)
      return FORM_MIN;
    else if (r < 86)
      return FORM_PAD;
    else if (r < 93)
      return FORM_LONG;
    return FORM_SPILL;
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(127);
      4, 5:    return $urandom_range(16383);
      6:       return $urandom_range(2097151);
      default: return $urandom;
    endcase
  endfunction

  task automatic put_list(input int count, input int deltas);
    put_varint(count, pick_form());
    for (int i = 0; i < deltas; i++)
      put_varint(pick_delta(), pick_form());
    lists_sent++;
  endtask

  // output side stall pattern, with long hold-offs
  initial begin
    int cyc;
    int pct;
    int seg;
    bit held;
    out_stall = 1'b0;
    cyc = 0;
    held = 1'b0;
    forever begin
      if ((cyc >= 400 && !held) || $urandom_range(29) == 0) begin
        held = 1'b1;
        holds++;
        seg = $urandom_range(150, 300);
        repeat (seg) begin
          @(posedge clk);
          out_stall <= 1'b1;
          cyc++;
        end
      end else begin
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 60;
          default: pct = 90;
        endcase
        seg = $urandom_range(20, 150);
        repeat (seg) begin
          @(posedge clk);
          out_stall <= ($urandom_range(99) < pct);
          cyc++;
        end
      end
    end
  end

  initial begin
    int count;
    int r;
    int last_drain;
    int goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    sent = 0;
    lists_sent = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, largest delta, wrap past the top
    put_varint(0, FORM_MIN);
    put_varint(1, FORM_MIN);
    put_varint('1, FORM_MIN);
    put_varint(2, FORM_MIN);
    put_varint('1, FORM_MIN);
    put_varint(2, FORM_MIN);
    // six byte count, then a delta with bits above the top
    put_byte(8'h81);
    repeat (4) put_byte(8'h80);
    put_byte(8'h00);
    repeat (4) put_byte(8'h80);
    put_byte(8'h70);
    lists_sent += 4;
    wait_drained();

    goal = sent + RAND_REQS;
    last_drain = sent;
    while (sent < goal) begin
      r = $urandom_range(99);
      if (r < 84) begin
        count = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
        put_list(count, count);
      end else if (r < 92) begin
        count = $urandom_range(2, 12);
        put_list(count, $urandom_range(0, count - 1));
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(127)));
      end
      if (sent - last_drain > 300) begin
        wait_drained();
        last_drain = sent;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run: %0d bytes in %0d lists, %0d results compared, %0d overlong, %0d hold-offs",
             sent, lists_sent, checked, overlong_hits, holds);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results still due", outstanding);
    $display("tb: errors");
    $finish;
  end

endmodule
